/* design/link_status_string_watcher_macros.svh */
// Assertion macros for the link status string watcher.
`ifndef LINK_STATUS_STRING_WATCHER_MACROS_SVH
`define LINK_STATUS_STRING_WATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define LSW_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lsw assertion failed");
`define LSW_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsw assertion failed");
`define LSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsw assertion failed");
`else
`define LSW_ASSERT_ALWAYS(label, clk, rst, cond)
`define LSW_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/lsw_pkg.sv */
// Package with phase codes, match strings and the result type of the watcher.
package lsw_pkg;

  localparam int PosW = 4;

  typedef enum logic [1:0] {
    PH_AWAIT_CONNECT = 2'd0,
    PH_AWAIT_EOL     = 2'd1,
    PH_CONNECTED     = 2'd2
  } phase_t;

  localparam logic [PosW-1:0] ConnectLen = 4'd7;
  localparam logic [PosW-1:0] EolLen     = 4'd2;
  localparam logic [PosW-1:0] DisconnLen = 4'd10;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       link_up_event;
    logic       link_down_event;
    logic [1:0] phase_now;
  } lsw_result_t;

  function automatic logic [7:0] connect_char(input logic [PosW-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "O";
      4'd2:    c = "N";
      4'd3:    c = "N";
      4'd4:    c = "E";
      4'd5:    c = "C";
      default: c = "T";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] eol_char(input logic [PosW-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'd13;
      default: c = 8'd10;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] disconn_char(input logic [PosW-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "D";
      4'd1:    c = "I";
      4'd2:    c = "S";
      4'd3:    c = "C";
      4'd4:    c = "O";
      4'd5:    c = "N";
      4'd6:    c = "N";
      4'd7:    c = "E";
      4'd8:    c = "C";
      default: c = "T";
    endcase
    return c;
  endfunction

endpackage

/* design/lsw_ifs.sv */
// Handshake channel interfaces for received bytes and watcher results.
interface lsw_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lsw_res_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       link_up_event;
  logic       link_down_event;
  logic [1:0] phase_now;

  modport source (
    output valid, output data_valid, output data_byte, output link_up_event,
    output link_down_event, output phase_now, input ready
  );
  modport sink (
    input valid, input data_valid, input data_byte, input link_up_event,
    input link_down_event, input phase_now, output ready
  );
endinterface

/* design/lsw_step.sv */
// Phase and match position update for one received byte.
module lsw_step
  import lsw_pkg::*;
(
  input  phase_t                phase,
  input  logic [PosW-1:0]       pos,
  input  logic [7:0]            rx_byte,
  output phase_t                phase_next,
  output logic [PosW-1:0]       pos_next,
  output lsw_result_t           result
);

  logic [7:0]      exp_char;
  logic [PosW-1:0] str_len;
  logic [PosW-1:0] pos_eff;
  logic            hit;
  logic            done;

  always_comb begin
    case (phase)
      PH_CONNECTED: begin
        str_len = DisconnLen;
      end
      PH_AWAIT_EOL: begin
        str_len = EolLen;
      end
      default: begin
        str_len = ConnectLen;
      end
    endcase
    pos_eff = (pos >= str_len) ? '0 : pos;
    case (phase)
      PH_CONNECTED: begin
        exp_char = disconn_char(pos_eff);
      end
      PH_AWAIT_EOL: begin
        exp_char = eol_char(pos_eff);
      end
      default: begin
        exp_char = connect_char(pos_eff);
      end
    endcase
    hit  = (rx_byte == exp_char);
    done = hit && (pos_eff == str_len - 4'd1);
  end

  always_comb begin
    pos_next = (hit && !done) ? pos_eff + 4'd1 : '0;
    case (phase)
      PH_CONNECTED: begin
        phase_next = done ? PH_AWAIT_CONNECT : PH_CONNECTED;
      end
      PH_AWAIT_EOL: begin
        phase_next = done ? PH_CONNECTED : PH_AWAIT_EOL;
      end
      default: begin
        phase_next = done ? PH_AWAIT_EOL : PH_AWAIT_CONNECT;
      end
    endcase
  end

  always_comb begin
    result.data_valid      = (phase == PH_CONNECTED);
    result.data_byte       = (phase == PH_CONNECTED) ? rx_byte : 8'd0;
    result.link_up_event   = (phase == PH_AWAIT_EOL) && done;
    result.link_down_event = (phase == PH_CONNECTED) && done;
    result.phase_now       = phase_next;
  end

endmodule

/* design/link_status_string_watcher.sv */
// Top level of the link status string watcher.
//
// Channel rx carries one received byte per transfer; channel res returns
// exactly one result per byte, in order: forwarded data while connected,
// link up when the line end after CONNECT completes, link down when
// DISCONNECT completes, and the phase after the byte.
// A byte taken from rx sits in the input register, is matched against
// the expected character by the step logic, and moves into the result
// register once that register is empty or being read out; res.valid rises
// with the loaded result, which can then transfer.
// One byte per cycle is sustained while res.ready stays high, set by the
// single compare and advance between the input and result registers.
// Reset clears the valid flags of both registers and puts the watcher in
// the await-connect phase at position zero. When res.ready is low the result
// register holds, the input register fills with one more byte, and rx.ready
// then drops until the result is taken.
`include "link_status_string_watcher_macros.svh"
module link_status_string_watcher
  import lsw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lsw_rx_if.sink    rx,
  lsw_res_if.source res
);

  logic            s1_valid;
  logic [7:0]      s1_byte;
  phase_t          phase;
  phase_t          phase_next;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  lsw_result_t     step_res;
  logic            s2_load;
  logic            s1_adv;

  assign s2_load  = !res.valid || res.ready;
  assign s1_adv   = s1_valid && s2_load;
  assign rx.ready = !s1_valid || s2_load;

  lsw_step u_step (
    .phase      (phase),
    .pos        (pos),
    .rx_byte    (s1_byte),
    .phase_next (phase_next),
    .pos_next   (pos_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // advance match state only when the byte moves on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_AWAIT_CONNECT;
      pos   <= '0;
    end else if (s1_adv) begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s2_load) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res.data_valid      <= step_res.data_valid;
      res.data_byte       <= step_res.data_byte;
      res.link_up_event   <= step_res.link_up_event;
      res.link_down_event <= step_res.link_down_event;
      res.phase_now       <= step_res.phase_now;
    end
  end

  `LSW_ASSERT_ALWAYS(a_pos_range, clk, rst, pos < DisconnLen)
  `LSW_ASSERT_SAME(a_no_dual_event, clk, rst, res.valid,
                   !(res.link_up_event && res.link_down_event))
  `LSW_ASSERT_SAME(a_up_connected, clk, rst, res.valid && res.link_up_event,
                   res.phase_now == PH_CONNECTED)
  `LSW_ASSERT_NEXT(a_fwd_connected, clk, rst, s1_adv && phase == PH_CONNECTED,
                   res.valid && res.data_valid)

endmodule

/* tb/link_status_string_watcher_tb.sv */
// Testbench for the link status string watcher: random byte stream, scoreboard check.
`timescale 1ns / 100ps
module link_status_string_watcher_tb
  import lsw_pkg::*;
;

  localparam int          NumRandomBytes = 2000;
  localparam int          HoldOffCycles  = 100;
  localparam int          IdleLimit      = 2000;
  localparam int          DrainCycles    = 10;
  localparam logic [7:0]  CR             = 8'h0D;
  localparam logic [7:0]  LF             = 8'h0A;

  class link_scoreboard;
    phase_t      phase;
    int          match_pos;
    string       connect_word;
    string       line_end;
    string       disconnect_word;
    lsw_result_t expected_results[$];
    int          mismatches;

    function new();
      connect_word    = "CONNECT";
      disconnect_word = "DISCONNECT";
      line_end        = "..";
      line_end[0]     = CR;
      line_end[1]     = LF;
      phase           = PH_AWAIT_CONNECT;
      match_pos       = 0;
      mismatches      = 0;
    endfunction

    task report(string what, int got, int exp);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, exp);
      mismatches++;
    endtask

    function void note_byte(logic [7:0] b);
      lsw_result_t r;
      string       word;
      int          next_pos;
      r = '0;
      r.data_valid = (phase == PH_CONNECTED);
      r.data_byte  = r.data_valid ? b : 8'h00;
      case (phase)
        PH_CONNECTED: word = disconnect_word;
        PH_AWAIT_EOL: word = line_end;
        default:      word = connect_word;
      endcase
      next_pos = (b == word[match_pos]) ? match_pos + 1 : 0;
      if (next_pos == word.len()) begin
        match_pos = 0;
        case (phase)
          PH_AWAIT_EOL: begin
            phase = PH_CONNECTED;
            r.link_up_event = 1'b1;
          end
          PH_CONNECTED: begin
            phase = PH_AWAIT_CONNECT;
            r.link_down_event = 1'b1;
          end
          default: phase = PH_AWAIT_EOL;
        endcase
      end else begin
        match_pos = next_pos;
      end
      r.phase_now = phase;
      expected_results.push_back(r);
    endfunction

    task check_result(lsw_result_t got);
      lsw_result_t exp;
      if (expected_results.size() == 0) begin
        report("unexpected result", got, 0);
        return;
      end
      exp = expected_results.pop_front();
      if (got.data_valid !== exp.data_valid)
        report("data_valid", got.data_valid, exp.data_valid);
      if (got.data_byte !== exp.data_byte)
        report("data_byte", got.data_byte, exp.data_byte);
      if (got.link_up_event !== exp.link_up_event)
        report("link_up_event", got.link_up_event, exp.link_up_event);
      if (got.link_down_event !== exp.link_down_event)
        report("link_down_event", got.link_down_event, exp.link_down_event);
      if (got.phase_now !== exp.phase_now)
        report("phase_now", got.phase_now, exp.phase_now);
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lsw_rx_if  rx_ch();
  lsw_res_if res_ch();

  link_status_string_watcher i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  link_scoreboard sb = new();

  int bytes_sent;
  int burst_left;
  bit steady;
  bit hold_off_req;
  int idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    lsw_result_t got;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) sb.note_byte(rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready) begin
        got.data_valid      = res_ch.data_valid;
        got.data_byte       = res_ch.data_byte;
        got.link_up_event   = res_ch.link_up_event;
        got.link_down_event = res_ch.link_down_event;
        got.phase_now       = res_ch.phase_now;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("link_status_string_watcher verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mode;
    int span;
    int phase_cnt;
    res_ch.ready = 1'b0;
    phase_cnt = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_off_req = 1'b0;
        @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        repeat (span) begin
          if (hold_off_req) break;
          phase_cnt++;
          case (mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= (phase_cnt % 4 != 0);
            default: res_ch.ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  function automatic string line_end_text();
    string s;
    s    = "..";
    s[0] = CR;
    s[1] = LF;
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line_end();
    send_byte(CR);
    send_byte(LF);
  endtask

  task automatic send_broken(input string s);
    int         k;
    logic [7:0] b;
    k = $urandom_range(1, s.len() - 1);
    for (int i = 0; i < k; i++) send_byte(s[i]);
    b = 8'($urandom_range(0, 255));
    while (b == s[k]) b = 8'($urandom_range(0, 255));
    send_byte(b);
  endtask

  task automatic send_user_data();
    int n;
    int pick;
    n = $urandom_range(0, 16);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_byte(8'($urandom_range(0, 255)));
      else if (pick < 8) send_broken("DISCONNECT");
      else send_byte("D");
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int  pick;
    bit  hold_done;
    bit  pause_done;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    bytes_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    hold_off_req  = 1'b0;
    idle_cycles   = 0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text("CCONNECT");
    send_byte(CR);
    send_byte(8'hFF);
    send_line_end();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("DISCONNECT");
    wait_drained();

    while (bytes_sent < NumRandomBytes) begin
      steady = ($urandom_range(0, 9) == 0);
      if (!hold_done && bytes_sent > NumRandomBytes / 3) begin
        hold_done    = 1'b1;
        steady       = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) send_byte(8'($urandom_range(0, 255)));
        steady = 1'b0;
      end
      if (!pause_done && bytes_sent > 2 * NumRandomBytes / 3) begin
        pause_done = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
        send_text("CONNECT");
        if ($urandom_range(0, 4) == 0) send_byte(CR);
        send_line_end();
        send_user_data();
        send_text("DISCONNECT");
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 8) begin
        send_broken("CONNECT");
      end else begin
        send_text("CONNECT");
        send_broken(line_end_text());
        send_line_end();
        send_user_data();
        send_broken("DISCONNECT");
        send_text("DISCONNECT");
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("link_status_string_watcher verification clean");
    end else begin
      $display("link_status_string_watcher verification failed");
    end
    $finish;
  end

endmodule
